// ===== hdl/mtep_pkg.sv =====
// Package for the MIDI track event parser: item types, byte classes,
// parse phases and byte constants. No dependencies.
`timescale 1ns / 1ps
package mtep_pkg;

   // Input item: one byte of a track chunk body with its framing flags.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_start;
      logic       track_end;
      logic [7:0] track_number;
      logic       file_start;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] tick;
      logic [3:0]  channel;
      logic [7:0]  track;
      logic [3:0]  msg_type;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [23:0] tempo_value;
   } rsp_type;

   // Classification of a byte, worked out by the front end.
   typedef struct packed {
      logic is_meta;
      logic is_sysex;
      logic is_status;
      logic is_bad_system;
      logic is_blank;
      logic is_text_type;
      logic is_tempo_type;
   } byte_class_type;

   // Queue entry between front and back.
   typedef struct packed {
      req_type        req;
      byte_class_type cls;
   } queue_item_type;

   typedef enum logic [3:0] {
      PH_DELTA,
      PH_STATUS,
      PH_META_TYPE,
      PH_META_LEN,
      PH_SYSEX_LEN,
      PH_TEMPO,
      PH_TEXT,
      PH_SKIP,
      PH_DATA1,
      PH_DATA2
   } phase_type;

   localparam logic [1:0] KIND_CHANNEL    = 2'd0;
   localparam logic [1:0] KIND_TEMPO      = 2'd1;
   localparam logic [1:0] KIND_LOOP_START = 2'd2;
   localparam logic [1:0] KIND_LOOP_END   = 2'd3;

   localparam logic [7:0] BYTE_META       = 8'hFF;
   localparam logic [7:0] BYTE_SYSEX      = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_ESC  = 8'hF7;
   localparam logic [7:0] META_TEMPO      = 8'h51;
   localparam logic [7:0] META_TEXT_FIRST = 8'h01;
   localparam logic [7:0] META_TEXT_LAST  = 8'h07;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_LOOP_START = 8'h5B;
   localparam logic [7:0] CHAR_LOOP_END   = 8'h5D;

   localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
   localparam logic [3:0] MSG_POLY_AT    = 4'hA;
   localparam logic [3:0] MSG_PROGRAM    = 4'hC;
   localparam logic [3:0] MSG_CHANNEL_AT = 4'hD;
   localparam logic [3:0] NIBBLE_SYSTEM  = 4'hF;

endpackage

// ===== hdl/mtep_front.sv =====
// Front end: accepts input items and classifies each byte for the parser.
// Depends on mtep_pkg.
`timescale 1ns / 1ps
module mtep_front (
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mtep_pkg::req_type       req_data,
   input  logic                    queue_full,
   output logic                    push,
   output mtep_pkg::queue_item_type push_item
);
   import mtep_pkg::*;

   logic [7:0]     b;
   byte_class_type cls;

   assign b = req_data.data_byte;

   // Byte classes used by the status, meta type and text phases.
   always_comb begin
      cls.is_meta       = (b == BYTE_META);
      cls.is_sysex      = (b == BYTE_SYSEX) || (b == BYTE_SYSEX_ESC);
      cls.is_status     = b[7];
      cls.is_bad_system = (b[7:4] == NIBBLE_SYSTEM) && !cls.is_meta && !cls.is_sysex;
      cls.is_blank      = (b == CHAR_SPACE) || (b == CHAR_TAB) ||
                          (b == CHAR_CR) || (b == CHAR_LF);
      cls.is_text_type  = (b >= META_TEXT_FIRST) && (b <= META_TEXT_LAST);
      cls.is_tempo_type = (b == META_TEMPO);
   end

   // An item is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.req = req_data;
      push_item.cls = cls;
   end
endmodule

// ===== hdl/mtep_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on mtep_pkg.
`timescale 1ns / 1ps
module mtep_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mtep_pkg::queue_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output mtep_pkg::queue_item_type pop_item
);
   import mtep_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   queue_item_type    mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

// ===== hdl/mtep_back.sv =====
// Back end: track parse state machine and the result register.
// Depends on mtep_pkg.
`timescale 1ns / 1ps
module mtep_back #(
   parameter int TEXT_SCAN_BYTES = 32,
   parameter int VLQ_MAX_BYTES   = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  mtep_pkg::queue_item_type item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mtep_pkg::rsp_type        rsp_data
);
   import mtep_pkg::*;

   logic [63:0] tick_ff, tick_in;
   logic [7:0]  run_status_ff, run_status_in;
   phase_type   phase_ff, phase_in;
   logic [27:0] vlq_acc_ff, vlq_acc_in;
   logic [2:0]  vlq_cnt_ff, vlq_cnt_in;
   logic        meta_text_ff, meta_text_in;
   logic        meta_tempo_ff, meta_tempo_in;
   logic [27:0] remain_ff, remain_in;
   logic [5:0]  text_seen_ff, text_seen_in;
   logic [1:0]  text_nb_ff, text_nb_in;
   logic [7:0]  text_char_ff, text_char_in;
   logic [7:0]  cur_status_ff, cur_status_in;
   logic [7:0]  held_ff, held_in;
   logic [23:0] tempo_ff, tempo_in;
   logic        loop_start_ff, loop_start_in;
   logic        loop_end_ff, loop_end_in;
   logic        err_ff, err_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;

   logic        emit;
   rsp_type     res;
   logic [7:0]  b;
   logic [27:0] acc_n;
   logic [2:0]  cnt_n;
   logic [3:0]  mtype;

   assign b   = item.req.data_byte;
   assign pop = item_valid && (!out_valid_ff || rsp_ready);

   // One parse step for the item at the head of the queue.
   always_comb begin
      tick_in       = tick_ff;
      run_status_in = run_status_ff;
      phase_in      = phase_ff;
      vlq_acc_in    = vlq_acc_ff;
      vlq_cnt_in    = vlq_cnt_ff;
      meta_text_in  = meta_text_ff;
      meta_tempo_in = meta_tempo_ff;
      remain_in     = remain_ff;
      text_seen_in  = text_seen_ff;
      text_nb_in    = text_nb_ff;
      text_char_in  = text_char_ff;
      cur_status_in = cur_status_ff;
      held_in       = held_ff;
      tempo_in      = tempo_ff;
      loop_start_in = loop_start_ff;
      loop_end_in   = loop_end_ff;
      err_in        = err_ff;
      emit          = 1'b0;
      res           = '0;
      acc_n         = '0;
      cnt_n         = '0;
      mtype         = '0;

      if (item.req.file_start) begin
         loop_start_in = 1'b0;
         loop_end_in   = 1'b0;
      end
      if (item.req.track_start) begin
         tick_in       = '0;
         run_status_in = '0;
         err_in        = 1'b0;
         phase_in      = PH_DELTA;
         vlq_acc_in    = '0;
         vlq_cnt_in    = '0;
         remain_in     = '0;
      end

      if (!err_in) begin
         case (phase_in)
            PH_STATUS: begin
               if (item.cls.is_meta) begin
                  run_status_in = '0;
                  phase_in      = PH_META_TYPE;
               end else if (item.cls.is_sysex) begin
                  run_status_in = '0;
                  vlq_acc_in    = '0;
                  vlq_cnt_in    = '0;
                  phase_in      = PH_SYSEX_LEN;
               end else if (item.cls.is_bad_system) begin
                  err_in = 1'b1;
               end else if (item.cls.is_status) begin
                  run_status_in = b;
                  cur_status_in = b;
                  phase_in      = PH_DATA1;
               end else if (run_status_in == '0) begin
                  err_in = 1'b1;
               end else begin
                  // Running status: this byte is the first data byte.
                  cur_status_in = run_status_in;
                  held_in       = b;
                  phase_in      = PH_DELTA;
                  if (cur_status_in[7:4] == MSG_PROGRAM) begin
                     emit             = 1'b1;
                     res.kind         = KIND_CHANNEL;
                     res.channel      = cur_status_in[3:0];
                     res.track        = item.req.track_number;
                     res.msg_type     = MSG_PROGRAM;
                     res.first_data   = b;
                  end else if (cur_status_in[7:4] != MSG_CHANNEL_AT) begin
                     phase_in = PH_DATA2;
                  end
               end
            end
            PH_META_TYPE: begin
               meta_text_in  = item.cls.is_text_type;
               meta_tempo_in = item.cls.is_tempo_type;
               text_seen_in  = '0;
               text_nb_in    = '0;
               text_char_in  = '0;
               vlq_acc_in    = '0;
               vlq_cnt_in    = '0;
               phase_in      = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
               acc_n      = {vlq_acc_in[20:0], b[6:0]};
               cnt_n      = vlq_cnt_in + 3'd1;
               vlq_acc_in = acc_n;
               vlq_cnt_in = cnt_n;
               if (b[7]) begin
                  if (cnt_n >= 3'(VLQ_MAX_BYTES)) begin
                     err_in = 1'b1;
                  end
               end else begin
                  vlq_cnt_in = '0;
                  remain_in  = acc_n;
                  if (phase_in == PH_META_LEN && meta_tempo_in && acc_n == 28'd3) begin
                     tempo_in = '0;
                     phase_in = PH_TEMPO;
                  end else if (phase_in == PH_META_LEN && meta_text_in) begin
                     if (acc_n == '0) begin
                        phase_in = PH_DELTA;
                        if (text_nb_in == 2'd1) begin
                           if (text_char_in == CHAR_LOOP_START && !loop_start_in) begin
                              loop_start_in = 1'b1;
                              emit          = 1'b1;
                              res.kind      = KIND_LOOP_START;
                           end else if (text_char_in == CHAR_LOOP_END && !loop_end_in) begin
                              loop_end_in = 1'b1;
                              emit        = 1'b1;
                              res.kind    = KIND_LOOP_END;
                           end
                        end
                     end else begin
                        phase_in = PH_TEXT;
                     end
                  end else begin
                     phase_in = (acc_n == '0) ? PH_DELTA : PH_SKIP;
                  end
               end
            end
            PH_TEMPO: begin
               tempo_in  = {tempo_in[15:0], b};
               remain_in = remain_in - 28'd1;
               if (remain_in == '0) begin
                  phase_in        = PH_DELTA;
                  emit            = 1'b1;
                  res.kind        = KIND_TEMPO;
                  res.tempo_value = tempo_in;
               end
            end
            PH_TEXT: begin
               // Only the first bytes of the text are scanned.
               if (text_seen_in < 6'(TEXT_SCAN_BYTES)) begin
                  if (!item.cls.is_blank) begin
                     if (text_nb_in == 2'd0) begin
                        text_char_in = b;
                     end
                     if (text_nb_in < 2'd2) begin
                        text_nb_in = text_nb_in + 2'd1;
                     end
                  end
                  text_seen_in = text_seen_in + 6'd1;
               end
               remain_in = remain_in - 28'd1;
               if (remain_in == '0) begin
                  phase_in = PH_DELTA;
                  if (text_nb_in == 2'd1) begin
                     if (text_char_in == CHAR_LOOP_START && !loop_start_in) begin
                        loop_start_in = 1'b1;
                        emit          = 1'b1;
                        res.kind      = KIND_LOOP_START;
                     end else if (text_char_in == CHAR_LOOP_END && !loop_end_in) begin
                        loop_end_in = 1'b1;
                        emit        = 1'b1;
                        res.kind    = KIND_LOOP_END;
                     end
                  end
               end
            end
            PH_SKIP: begin
               remain_in = remain_in - 28'd1;
               if (remain_in == '0) begin
                  phase_in = PH_DELTA;
               end
            end
            PH_DATA1: begin
               held_in  = b;
               phase_in = PH_DELTA;
               if (cur_status_in[7:4] == MSG_PROGRAM) begin
                  emit           = 1'b1;
                  res.kind       = KIND_CHANNEL;
                  res.channel    = cur_status_in[3:0];
                  res.track      = item.req.track_number;
                  res.msg_type   = MSG_PROGRAM;
                  res.first_data = b;
               end else if (cur_status_in[7:4] != MSG_CHANNEL_AT) begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               phase_in = PH_DELTA;
               mtype    = cur_status_in[7:4];
               if (mtype != MSG_POLY_AT) begin
                  if (mtype == MSG_NOTE_ON && b == '0) begin
                     mtype = MSG_NOTE_OFF;
                  end
                  emit            = 1'b1;
                  res.kind        = KIND_CHANNEL;
                  res.channel     = cur_status_in[3:0];
                  res.track       = item.req.track_number;
                  res.msg_type    = mtype;
                  res.first_data  = held_in;
                  res.second_data = b;
               end
            end
            default: begin
               // Delta time: a variable-length number added to the tick.
               if (vlq_cnt_in == '0) begin
                  vlq_acc_in = '0;
               end
               phase_in   = PH_DELTA;
               acc_n      = {vlq_acc_in[20:0], b[6:0]};
               cnt_n      = vlq_cnt_in + 3'd1;
               vlq_acc_in = acc_n;
               vlq_cnt_in = cnt_n;
               if (b[7]) begin
                  if (cnt_n >= 3'(VLQ_MAX_BYTES)) begin
                     err_in = 1'b1;
                  end
               end else begin
                  vlq_cnt_in = '0;
                  tick_in    = tick_in + {36'd0, acc_n};
                  vlq_acc_in = '0;
                  phase_in   = PH_STATUS;
               end
            end
         endcase
      end

      res.tick = tick_in;

      if (item.req.track_end) begin
         phase_in   = PH_DELTA;
         vlq_acc_in = '0;
         vlq_cnt_in = '0;
         remain_in  = '0;
         err_in     = 1'b0;
      end
   end

   // Result register: loaded on a step that gives a result, freed when taken.
   always_comb begin
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = emit;
         out_data_in  = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         run_status_ff <= '0;
         phase_ff      <= PH_DELTA;
         vlq_acc_ff    <= '0;
         vlq_cnt_ff    <= '0;
         meta_text_ff  <= 1'b0;
         meta_tempo_ff <= 1'b0;
         remain_ff     <= '0;
         text_seen_ff  <= '0;
         text_nb_ff    <= '0;
         text_char_ff  <= '0;
         cur_status_ff <= '0;
         held_ff       <= '0;
         tempo_ff      <= '0;
         loop_start_ff <= 1'b0;
         loop_end_ff   <= 1'b0;
         err_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            tick_ff       <= tick_in;
            run_status_ff <= run_status_in;
            phase_ff      <= phase_in;
            vlq_acc_ff    <= vlq_acc_in;
            vlq_cnt_ff    <= vlq_cnt_in;
            meta_text_ff  <= meta_text_in;
            meta_tempo_ff <= meta_tempo_in;
            remain_ff     <= remain_in;
            text_seen_ff  <= text_seen_in;
            text_nb_ff    <= text_nb_in;
            text_char_ff  <= text_char_in;
            cur_status_ff <= cur_status_in;
            held_ff       <= held_in;
            tempo_ff      <= tempo_in;
            loop_start_ff <= loop_start_in;
            loop_end_ff   <= loop_end_in;
            err_ff        <= err_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
endmodule

// ===== hdl/midi_track_event_parser_top.sv =====
// Top level of the MIDI track event parser: front end, queue, back end.
// Depends on mtep_pkg, mtep_front, mtep_queue and mtep_back.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   req_data (mtep_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_ready   rsp_data (mtep_pkg::rsp_type)
//
// One byte is taken per cycle while the queue is not full; each byte is one
// parse step in the back end. A result passes through the queue, then the
// result register. A stalled result stops the back end only; the four-entry
// queue keeps accepting bytes until it fills. Reset clears all parse state.
`timescale 1ns / 1ps
module midi_track_event_parser_top #(
   parameter int TEXT_SCAN_BYTES = 32,
   parameter int VLQ_MAX_BYTES   = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mtep_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtep_pkg::rsp_type rsp_data
);
   import mtep_pkg::*;

   logic           queue_full;
   logic           push;
   queue_item_type push_item;
   logic           pop;
   logic           pop_valid;
   queue_item_type pop_item;

   mtep_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   mtep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   mtep_back #(
      .TEXT_SCAN_BYTES (TEXT_SCAN_BYTES),
      .VLQ_MAX_BYTES   (VLQ_MAX_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );
endmodule
